// File: design/aabb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

	localparam int MAX_OBJECTS  = 8;
	localparam int IDX_W        = $clog2(MAX_OBJECTS);
	localparam int CNT_W        = $clog2(MAX_OBJECTS + 1);
	localparam int AXES         = 3;
	localparam int RESULT_LIMIT = 28;
	localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

	// command codes
	localparam logic [2:0] CMD_REGISTER   = 3'd0;
	localparam logic [2:0] CMD_SET_BOX    = 3'd1;
	localparam logic [2:0] CMD_SET_POSE   = 3'd2;
	localparam logic [2:0] CMD_UNREGISTER = 3'd3;
	localparam logic [2:0] CMD_CLEAR      = 3'd4;
	localparam logic [2:0] CMD_DETECT     = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PAIR     = 3'd1;
	localparam logic [2:0] ST_NO_PAIRS = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic [15:0]        object_id;
		logic [1:0]         axis;
		logic signed [31:0] local_min;
		logic signed [31:0] local_max;
		logic signed [31:0] position;
		logic signed [15:0] scale;
		logic               enabled;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] first_object;
		logic [15:0] second_object;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_EXEC,
		OP_XF,
		OP_LDI,
		OP_PUSH,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] ent;
		logic [1:0]       axis;
		logic [1:0]       phase;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0]             command;
		logic [CNT_W-1:0]       count;
		logic [MAX_OBJECTS-1:0] en;
		logic                   out_busy;
		logic                   pend_valid;
		logic                   hit;
	} dp_sts_t;

	// floor shift of a Q24.24 product down to Q16.16, saturated to 32 bits
	function automatic logic signed [31:0] sat_prod(input logic signed [47:0] p);
		logic signed [47:0] s;
		s = p >>> 8;
		if (s[47:31] == {17{1'b0}} || s[47:31] == {17{1'b1}})
			return s[31:0];
		else if (s[47])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	// saturated 32-bit signed add
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] == s[31])
			return s[31:0];
		else if (s[32])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

`default_nettype wire

// File: design/aabb_pair_overlap_broad_phase_core.sv
// Broad-phase box overlap engine over a table of up to eight objects.
// Input channel (in_valid/in_ready/in_item) takes one command item; the
// output channel (out_valid/out_ready/out_item) returns its result items.
// Table commands (register, set box, set pose, unregister, clear) latch the
// item in the input register, then load their result into the output
// register once it is free; only then is a new command taken. Detect first
// places every table entry in world space with one shared 32x16 multiplier,
// scaling low and high bounds and adding the position per axis, then walks
// all pairs i<j: it loads each enabled first entry, tests one pair a cycle
// unless a hit waits on the output register, and closes each row. Each
// colliding pair is one item, in table order; the final item of a command has
// last set, and no pairs gives one no-pairs item.
// Commands six and seven are dropped without a result.
// One command is worked on at a time; in_ready is high only while idle.
// Results sit in an output register: a stalled receiver holds the pair walk
// (and the next command) until the register is taken.
// Reset empties the table; registering a new id clears its box and pose.
`timescale 1ns / 1ps
`default_nettype none

module aabb_pair_overlap_broad_phase_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire aabb_pkg::in_item_t   in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output aabb_pkg::out_item_t    out_item
);
	import aabb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	aabb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aabb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table never holds more than its capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CNT_W'(MAX_OBJECTS))
		else $error("entry count above capacity");

	// an accepted item drops in_ready in the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// only pair items may leave last clear
	a_last_only_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |-> out_item.status == ST_PAIR)
		else $error("non-pair result without last");

	// the datapath never loads a new result over one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EXEC || cmd.op == OP_FIN) |-> !sts.out_busy)
		else $error("result register overwritten");

endmodule

`default_nettype wire

// File: design/aabb_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module aabb_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire aabb_pkg::in_item_t  in_item,
	output aabb_pkg::out_item_t   out_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire aabb_pkg::dp_cmd_t   cmd,
	output aabb_pkg::dp_sts_t     sts
);
	import aabb_pkg::*;

	in_item_t  in_q;
	out_item_t out_q;
	logic      out_valid_q;
	logic [CNT_W-1:0] count_q;

	logic [15:0]        id_q  [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0] en_q;
	logic signed [31:0] blo_q [MAX_OBJECTS][AXES];
	logic signed [31:0] bhi_q [MAX_OBJECTS][AXES];
	logic signed [31:0] pos_q [MAX_OBJECTS][AXES];
	logic signed [15:0] scl_q [MAX_OBJECTS][AXES];
	logic signed [31:0] wlo_q [MAX_OBJECTS][AXES];
	logic signed [31:0] whi_q [MAX_OBJECTS][AXES];

	logic signed [31:0] ilo_q [AXES];
	logic signed [31:0] ihi_q [AXES];
	logic [15:0]        iid_q;

	logic               pend_valid_q;
	logic [15:0]        pend_a_q;
	logic [15:0]        pend_b_q;

	logic signed [47:0] prod_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;

	logic               found;
	logic [IDX_W-1:0]   e_idx;
	logic               hit;
	logic signed [47:0] prod_d;
	logic signed [15:0] xs;
	logic signed [31:0] wl_d;
	logic signed [31:0] wh_d;
	logic               ax_ok;

	// id lookup, first match in table order
	always_comb begin
		found = 1'b0;
		e_idx = '0;
		for (int k = MAX_OBJECTS - 1; k >= 0; k--) begin
			if (CNT_W'(k) < count_q && id_q[k] == in_q.object_id) begin
				found = 1'b1;
				e_idx = IDX_W'(k);
			end
		end
	end

	// overlap of latched box i against world box at cmd.ent
	always_comb begin
		hit = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			if (!(ilo_q[a] <= whi_q[cmd.ent][a] && ihi_q[a] >= wlo_q[cmd.ent][a]))
				hit = 1'b0;
		end
	end

	// transform step: one multiplier shared by both bounds
	always_comb begin
		xs     = scl_q[cmd.ent][cmd.axis];
		prod_d = (cmd.phase == 2'd0) ? blo_q[cmd.ent][cmd.axis] * xs
		                             : bhi_q[cmd.ent][cmd.axis] * xs;
		if (xs < 0) begin
			wl_d = sat_add(hi_q, pos_q[cmd.ent][cmd.axis]);
			wh_d = sat_add(lo_q, pos_q[cmd.ent][cmd.axis]);
		end else begin
			wl_d = sat_add(lo_q, pos_q[cmd.ent][cmd.axis]);
			wh_d = sat_add(hi_q, pos_q[cmd.ent][cmd.axis]);
		end
		ax_ok = (in_q.axis <= AXIS_LAST);
	end

	// payload and table storage
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: in_q <= in_item;
			OP_EXEC: begin
				out_q <= '{status: ST_OK, first_object: 16'd0, second_object: 16'd0,
					last: 1'b1};
				unique case (in_q.command)
					CMD_REGISTER: begin
						if (found) begin
							en_q[e_idx] <= in_q.enabled;
						end else if (count_q >= CNT_W'(MAX_OBJECTS)) begin
							out_q.status <= ST_FULL;
						end else begin
							id_q[count_q[IDX_W-1:0]] <= in_q.object_id;
							en_q[count_q[IDX_W-1:0]] <= in_q.enabled;
							for (int a = 0; a < AXES; a++) begin
								blo_q[count_q[IDX_W-1:0]][a] <= '0;
								bhi_q[count_q[IDX_W-1:0]][a] <= '0;
								pos_q[count_q[IDX_W-1:0]][a] <= '0;
								scl_q[count_q[IDX_W-1:0]][a] <= '0;
							end
						end
					end
					CMD_SET_BOX: begin
						if (!found) begin
							out_q.status <= ST_NOT_FOUND;
						end else if (ax_ok) begin
							blo_q[e_idx][in_q.axis] <= in_q.local_min;
							bhi_q[e_idx][in_q.axis] <= in_q.local_max;
						end
					end
					CMD_SET_POSE: begin
						if (!found) begin
							out_q.status <= ST_NOT_FOUND;
						end else if (ax_ok) begin
							pos_q[e_idx][in_q.axis] <= in_q.position;
							scl_q[e_idx][in_q.axis] <= in_q.scale;
						end
					end
					CMD_UNREGISTER: begin
						if (!found) begin
							out_q.status <= ST_NOT_FOUND;
						end else begin
							for (int k = 0; k < MAX_OBJECTS - 1; k++) begin
								if (IDX_W'(k) >= e_idx) begin
									id_q[k]  <= id_q[k+1];
									en_q[k]  <= en_q[k+1];
									blo_q[k] <= blo_q[k+1];
									bhi_q[k] <= bhi_q[k+1];
									pos_q[k] <= pos_q[k+1];
									scl_q[k] <= scl_q[k+1];
								end
							end
						end
					end
					default: ;
				endcase
			end
			OP_XF: begin
				unique case (cmd.phase)
					2'd0: prod_q <= prod_d;
					2'd1: begin
						lo_q   <= sat_prod(prod_q);
						prod_q <= prod_d;
					end
					2'd2: hi_q <= sat_prod(prod_q);
					default: begin
						wlo_q[cmd.ent][cmd.axis] <= wl_d;
						whi_q[cmd.ent][cmd.axis] <= wh_d;
					end
				endcase
			end
			OP_LDI: begin
				iid_q <= id_q[cmd.ent];
				for (int a = 0; a < AXES; a++) begin
					ilo_q[a] <= wlo_q[cmd.ent][a];
					ihi_q[a] <= whi_q[cmd.ent][a];
				end
			end
			OP_PUSH: begin
				if (pend_valid_q)
					out_q <= '{status: ST_PAIR, first_object: pend_a_q,
						second_object: pend_b_q, last: 1'b0};
				pend_a_q <= iid_q;
				pend_b_q <= id_q[cmd.ent];
			end
			OP_FIN: begin
				if (pend_valid_q)
					out_q <= '{status: ST_PAIR, first_object: pend_a_q,
						second_object: pend_b_q, last: 1'b1};
				else
					out_q <= '{status: ST_NO_PAIRS, first_object: 16'd0,
						second_object: 16'd0, last: 1'b1};
			end
			default: ;
		endcase
	end

	// control state: entry count, output valid, pending pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_EXEC: begin
					out_valid_q <= 1'b1;
					unique case (in_q.command)
						CMD_REGISTER:
							if (!found && count_q < CNT_W'(MAX_OBJECTS))
								count_q <= count_q + CNT_W'(1);
						CMD_UNREGISTER:
							if (found)
								count_q <= count_q - CNT_W'(1);
						CMD_CLEAR: count_q <= '0;
						default: ;
					endcase
				end
				OP_PUSH: begin
					if (pend_valid_q)
						out_valid_q <= 1'b1;
					pend_valid_q <= 1'b1;
				end
				OP_FIN: begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign out_item = out_q;
	assign out_valid = out_valid_q;

	assign sts.command    = in_q.command;
	assign sts.count      = count_q;
	assign sts.en         = en_q;
	assign sts.out_busy   = out_valid_q;
	assign sts.pend_valid = pend_valid_q;
	assign sts.hit        = hit;

endmodule

`default_nettype wire

// File: design/aabb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module aabb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire aabb_pkg::dp_sts_t sts,
	output aabb_pkg::dp_cmd_t   cmd
);
	import aabb_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_XF, S_LDI, S_TEST, S_FIN} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [1:0]       ka_q;
	logic [1:0]       ph_q;
	logic [RES_W-1:0] cnt_q;

	logic en_i;
	logic en_j;
	logic j_in;
	logic i_has_j;
	logic blocked;

	always_comb begin
		en_i    = sts.en[i_q[IDX_W-1:0]];
		en_j    = sts.en[j_q[IDX_W-1:0]];
		j_in    = (j_q < sts.count);
		i_has_j = ((i_q + CNT_W'(1)) < sts.count);
		blocked = sts.pend_valid && sts.out_busy;
	end

	// datapath command for this cycle
	always_comb begin
		cmd.op    = OP_NONE;
		cmd.ent   = i_q[IDX_W-1:0];
		cmd.axis  = ka_q;
		cmd.phase = ph_q;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = OP_LOAD;
			S_EXEC: if (sts.command <= CMD_CLEAR && !sts.out_busy) cmd.op = OP_EXEC;
			S_XF:   cmd.op = OP_XF;
			S_LDI:  if (i_has_j && en_i) cmd.op = OP_LDI;
			S_TEST: begin
				cmd.ent = j_q[IDX_W-1:0];
				if (j_in && en_j && sts.hit && !blocked) cmd.op = OP_PUSH;
			end
			S_FIN:  if (!sts.out_busy) cmd.op = OP_FIN;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ka_q    <= '0;
			ph_q    <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.command == CMD_DETECT) begin
						cnt_q <= '0;
						i_q   <= '0;
						ka_q  <= '0;
						ph_q  <= '0;
						state_q <= (sts.count == '0) ? S_FIN : S_XF;
					end else if (sts.command > CMD_DETECT) begin
						state_q <= S_IDLE;
					end else if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_XF: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (ka_q == AXIS_LAST) begin
							ka_q <= '0;
							if (!i_has_j) begin
								i_q     <= '0;
								state_q <= S_LDI;
							end else begin
								i_q <= i_q + CNT_W'(1);
							end
						end else begin
							ka_q <= ka_q + 2'd1;
						end
					end
				end
				S_LDI: begin
					if (!i_has_j) begin
						state_q <= S_FIN;
					end else if (en_i) begin
						j_q     <= i_q + CNT_W'(1);
						state_q <= S_TEST;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_TEST: begin
					if (!j_in) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_LDI;
					end else if (!en_j || !sts.hit) begin
						j_q <= j_q + CNT_W'(1);
					end else if (!blocked) begin
						cnt_q <= cnt_q + RES_W'(1);
						if (cnt_q == RES_W'(RESULT_LIMIT - 1))
							state_q <= S_FIN;
						else
							j_q <= j_q + CNT_W'(1);
					end
				end
				S_FIN: if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
